FILE: rtl/arpc_pkg.sv
// Package for the ARP cache with request retry.
// Operation and result codes, controller states, command and status structs.
// No dependencies.
`default_nettype none
package arpc_pkg;

  localparam logic [1:0] MODE_LOOKUP = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_QUEUE  = 2'd2;
  localparam logic [1:0] MODE_TICK   = 2'd3;

  localparam logic [2:0] KIND_LOOKUP = 3'd0;
  localparam logic [2:0] KIND_INSERT = 3'd1;
  localparam logic [2:0] KIND_QUEUE  = 3'd2;
  localparam logic [2:0] KIND_SEND   = 3'd3;
  localparam logic [2:0] KIND_GIVEUP = 3'd4;
  localparam logic [2:0] KIND_DONE   = 3'd5;

  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_RETRY   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CSCAN,
    ST_PSCAN,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic load;
    logic cscan_start;
    logic cscan_step;
    logic pscan_start;
    logic pscan_step;
    logic emit;
    logic emit_done;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       cscan_end;
    logic       pscan_end;
  } sts_t;

endpackage
`default_nettype wire

FILE: rtl/arpc_ctrl.sv
// Controller state machine for the ARP cache.
// Sequences cache and pending scans; depends on arpc_pkg.
`default_nettype none
module arpc_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  output arpc_pkg::cmd_t      cmd_o,
  input  wire arpc_pkg::sts_t sts_i
);
  import arpc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    busy = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d = ST_CSCAN;
        end
      end
      ST_CSCAN: begin
        cmd_o.cscan_step = 1'b1;
        if (sts_i.cscan_end) begin
          cmd_o.pscan_start = 1'b1;
          state_d = ST_PSCAN;
        end
      end
      ST_PSCAN: begin
        cmd_o.pscan_step = 1'b1;
        if (sts_i.pscan_end) state_d = ST_RESULT;
      end
      ST_RESULT: begin
        cmd_o.emit_done = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

FILE: rtl/arpc_datapath.sv
// Datapath of the ARP cache: cache and pending memories, scan counters, results.
// Driven by arpc_ctrl commands; depends on arpc_pkg.
`default_nettype none
module arpc_datapath #(
  parameter int CACHE_ENTRIES   = 128,
  parameter int PENDING_ENTRIES = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire arpc_pkg::cmd_t cmd_i,
  output arpc_pkg::sts_t      sts_o,
  input  wire logic [1:0]     mode_i,
  input  wire logic [31:0]    ip_addr_i,
  input  wire logic [47:0]    mac_addr_i,
  input  wire logic           cfg_we_i,
  input  wire logic [0:0]     cfg_idx_i,
  input  wire logic           cfg_bad_i,
  input  wire logic [15:0]    cfg_data_i,
  output logic                res_valid_o,
  output logic [2:0]          kind_o,
  output logic [31:0]         result_ip_o,
  output logic [47:0]         result_mac_o,
  output logic                hit_o,
  output logic                accepted_o,
  output logic                last_o
);
  import arpc_pkg::*;

  localparam int CW = $clog2(CACHE_ENTRIES);
  localparam int PW = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;

  // Cache: valid in flops, payload in memory. Scan reads one slot a cycle.
  logic [CACHE_ENTRIES-1:0] cvalid_q;
  logic [31:0] cip_mem [CACHE_ENTRIES];
  logic [47:0] cmac_mem [CACHE_ENTRIES];
  logic [15:0] cage_mem [CACHE_ENTRIES];
  logic [PENDING_ENTRIES-1:0] pvalid_q;
  logic [31:0] pip_q [PENDING_ENTRIES];
  logic [3:0]  ptry_q [PENDING_ENTRIES];

  logic [15:0] tmo_q;
  logic [3:0]  lim_q;
  logic [1:0]  mode_q;
  logic [31:0] ip_q;
  logic [47:0] mac_q;
  logic [CW:0] cidx_q;   // read address issued
  logic [CW:0] ridx_q;   // slot whose data is in the read registers
  logic        rv_q;
  logic [31:0] rip_q;
  logic [47:0] rmac_q;
  logic [15:0] rage_q;
  logic [PW:0] pidx_q;
  logic        found_q, done_q, free_q, pfree_q;
  logic [47:0] fmac_q;
  logic [CW-1:0] fslot_q;
  logic [PW-1:0] pslot_q;

  logic [CW-1:0] ra, rs;
  logic [PW-1:0] pa;
  assign ra = cidx_q[CW-1:0];
  assign rs = ridx_q[CW-1:0];
  assign pa = pidx_q[PW-1:0];

  logic pv, pm;
  assign pv = (pidx_q < PW'(0) + (PW+1)'(PENDING_ENTRIES)) && pvalid_q[pa];
  assign pm = pv && (pip_q[pa] == ip_q);

  assign sts_o.mode = mode_q;
  assign sts_o.cscan_end = rv_q && (ridx_q == (CW+1)'(CACHE_ENTRIES - 1));
  assign sts_o.pscan_end = (pidx_q >= (PW+1)'(PENDING_ENTRIES - 1)) ||
                           (mode_q != MODE_TICK && pm);

  logic [15:0] age_n;
  assign age_n = (rage_q == 16'hFFFF) ? rage_q : rage_q + 16'd1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      ip_q <= ip_addr_i;
      mac_q <= mac_addr_i;
      fmac_q <= '0;
    end
    if (cmd_i.cscan_step && !cidx_q[CW]) begin
      rip_q <= cip_mem[ra];
      rmac_q <= cmac_mem[ra];
      rage_q <= cage_mem[ra];
    end
    if (cmd_i.cscan_step && rv_q) begin
      if (mode_q == MODE_LOOKUP && cvalid_q[rs] && rip_q == ip_q) fmac_q <= rmac_q;
      if (mode_q == MODE_INSERT && !cvalid_q[rs] && !free_q) fslot_q <= rs;
      if (mode_q == MODE_TICK && cvalid_q[rs]) cage_mem[rs] <= age_n;
    end
    if (cmd_i.cscan_step && rv_q && sts_o.cscan_end && mode_q == MODE_INSERT &&
        (free_q || !cvalid_q[rs])) begin
      cip_mem[(free_q ? fslot_q : rs)] <= ip_q;
      cmac_mem[(free_q ? fslot_q : rs)] <= mac_q;
      cage_mem[(free_q ? fslot_q : rs)] <= '0;
    end
    if (cmd_i.pscan_step && mode_q == MODE_QUEUE && !pv && !pfree_q
        && pidx_q < (PW+1)'(PENDING_ENTRIES)) pslot_q <= pa;
    if (cmd_i.emit_done && mode_q == MODE_QUEUE && !found_q && pfree_q) begin
      pip_q[pslot_q] <= ip_q;
      ptry_q[pslot_q] <= '0;
    end
    if (cmd_i.pscan_step && mode_q == MODE_TICK && pv && ptry_q[pa] < lim_q)
      ptry_q[pa] <= ptry_q[pa] + 4'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cvalid_q <= '0;
      pvalid_q <= '0;
      tmo_q <= 16'd15;
      lim_q <= 4'd5;
      cidx_q <= '0;
      ridx_q <= '0;
      rv_q <= 1'b0;
      pidx_q <= '0;
      found_q <= 1'b0;
      done_q <= 1'b0;
      free_q <= 1'b0;
      pfree_q <= 1'b0;
      res_valid_o <= 1'b0;
      kind_o <= '0;
      result_ip_o <= '0;
      result_mac_o <= '0;
      hit_o <= 1'b0;
      accepted_o <= 1'b0;
      last_o <= 1'b0;
    end else begin
      res_valid_o <= 1'b0;
      if (cfg_we_i && !cfg_bad_i) begin
        if (cfg_idx_i == CFG_TIMEOUT) tmo_q <= cfg_data_i;
        else lim_q <= cfg_data_i[3:0];
      end
      if (cmd_i.load) begin
        cidx_q <= '0;
        ridx_q <= '0;
        rv_q <= 1'b0;
        found_q <= 1'b0;
        done_q <= 1'b0;
        free_q <= 1'b0;
        pfree_q <= 1'b0;
      end
      if (cmd_i.cscan_step) begin
        if (!cidx_q[CW]) begin
          ridx_q <= cidx_q;
          cidx_q <= cidx_q + 1'b1;
          rv_q <= 1'b1;
        end else rv_q <= 1'b0;
        if (rv_q) begin
          if (mode_q == MODE_LOOKUP && cvalid_q[rs] && rip_q == ip_q) found_q <= 1'b1;
          if (mode_q == MODE_INSERT && !cvalid_q[rs]) free_q <= 1'b1;
          if (mode_q == MODE_TICK && cvalid_q[rs] && age_n > tmo_q) cvalid_q[rs] <= 1'b0;
          if (sts_o.cscan_end && mode_q == MODE_INSERT && (free_q || !cvalid_q[rs]))
            cvalid_q[free_q ? fslot_q : rs] <= 1'b1;
        end
      end
      if (cmd_i.pscan_start) pidx_q <= '0;
      if (cmd_i.pscan_step) begin
        pidx_q <= pidx_q + 1'b1;
        case (mode_q)
          MODE_INSERT: if (pm) begin
            pvalid_q[pa] <= 1'b0;
            done_q <= 1'b1;
          end
          MODE_QUEUE: begin
            if (pm) found_q <= 1'b1;
            if (!pv && pidx_q < (PW+1)'(PENDING_ENTRIES)) pfree_q <= 1'b1;
          end
          MODE_TICK: if (pv) begin
            res_valid_o <= 1'b1;
            kind_o <= (ptry_q[pa] >= lim_q) ? KIND_GIVEUP : KIND_SEND;
            result_ip_o <= pip_q[pa];
            result_mac_o <= '0;
            hit_o <= 1'b0;
            accepted_o <= 1'b0;
            last_o <= 1'b0;
            if (ptry_q[pa] >= lim_q) pvalid_q[pa] <= 1'b0;
          end
          default: ;
        endcase
      end
      if (cmd_i.emit_done) begin
        res_valid_o <= 1'b1;
        last_o <= 1'b1;
        result_mac_o <= '0;
        hit_o <= 1'b0;
        accepted_o <= 1'b0;
        result_ip_o <= ip_q;
        case (mode_q)
          MODE_LOOKUP: begin
            kind_o <= KIND_LOOKUP;
            hit_o <= found_q;
            result_mac_o <= fmac_q;
          end
          MODE_INSERT: begin
            kind_o <= KIND_INSERT;
            hit_o <= done_q;
            accepted_o <= free_q;
          end
          MODE_QUEUE: begin
            kind_o <= KIND_QUEUE;
            hit_o <= found_q;
            accepted_o <= !found_q && pfree_q;
            if (!found_q && pfree_q) pvalid_q[pslot_q] <= 1'b1;
          end
          default: begin
            kind_o <= KIND_DONE;
            result_ip_o <= '0;
          end
        endcase
      end
    end
  end

  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_done |=> (res_valid_o && last_o))
    else $error("final result missing");
  a_tick_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (kind_o == KIND_SEND || kind_o == KIND_GIVEUP)) |-> (!hit_o && !last_o))
    else $error("bad tick result");
  a_ins_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && kind_o == KIND_LOOKUP) |-> !accepted_o)
    else $error("lookup accepted");
endmodule
`default_nettype wire

FILE: rtl/arp_cache_with_request_retry_unit.sv
// Top level of the ARP cache with request retry.
// Instantiates arpc_ctrl and arpc_datapath; depends on arpc_pkg.
//
// Usage: assert start with mode_i, ip_addr_i, mac_addr_i while busy is low;
// the item is taken at that edge. Each operation scans all cache slots
// (one read a cycle through a registered memory port) and then up to
// PENDING_ENTRIES pending slots, one per cycle. The walks are followed by
// a result state that takes the final result; busy drops as that result
// is taken, so the next item can be taken while it is shown. A pending
// match on a non-tick item ends the pending walk early.
// Results appear at most one per cycle on the result ports with done_o
// high; a tick gives one send or give-up result per valid pending slot, then
// a tick-done result with last_o high. Every other item gives one result.
// The receiver cannot stall: results are shown once for one cycle.
// Configuration: cfg_we_i, cfg_idx_i, cfg_data_i, written while idle.
// Reset empties both tables and loads timeout 15 and retry limit 5.
`default_nettype none
module arp_cache_with_request_retry_unit #(
  parameter int CACHE_ENTRIES   = 128,
  parameter int PENDING_ENTRIES = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  mode_i,
  input  wire logic [31:0] ip_addr_i,
  input  wire logic [47:0] mac_addr_i,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  output logic             done_o,
  output logic [2:0]       kind_o,
  output logic [31:0]      result_ip_o,
  output logic [47:0]      result_mac_o,
  output logic             hit_o,
  output logic             accepted_o,
  output logic             last_o
);
  import arpc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  arpc_ctrl u_ctrl (
    .clk_i, .rst_ni, .start, .busy, .cmd_o(cmd), .sts_i(sts)
  );

  arpc_datapath #(
    .CACHE_ENTRIES(CACHE_ENTRIES), .PENDING_ENTRIES(PENDING_ENTRIES)
  ) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .mode_i, .ip_addr_i, .mac_addr_i,
    .cfg_we_i, .cfg_idx_i(cfg_idx_i[0]), .cfg_bad_i(cfg_idx_i[1]), .cfg_data_i,
    .res_valid_o(done_o), .kind_o, .result_ip_o, .result_mac_o,
    .hit_o, .accepted_o, .last_o
  );
endmodule
`default_nettype wire

FILE: sim/tb_top.sv
// Testbench for arp_cache_with_request_retry_unit: directed and random items
// checked against a built-in model of the ARP table and pending-request table.
// Depends on arpc_pkg and the RTL of the unit.
`timescale 1ns / 1ps
module tb_top;
  import arpc_pkg::*;

  localparam int NCACHE = 128;
  localparam int NPEND = 16;
  localparam int LIMIT = 600000;
  localparam logic [1:0] IDX_TIMEOUT = {1'b0, CFG_TIMEOUT};
  localparam logic [1:0] IDX_RETRY = {1'b0, CFG_RETRY};
  localparam logic [1:0] IDX_SPARE = 2'd2;

  typedef struct {
    logic [2:0]  kind;
    logic [31:0] ip;
    logic [47:0] mac;
    logic        hit;
    logic        acc;
    logic        last;
  } arp_result_t;

  logic clk_i, rst_ni, start, busy, done_o;
  logic [1:0] mode_i;
  logic [31:0] ip_addr_i;
  logic [47:0] mac_addr_i;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic [2:0] kind_o;
  logic [31:0] result_ip_o;
  logic [47:0] result_mac_o;
  logic hit_o, accepted_o, last_o;

  arp_cache_with_request_retry_unit uut (.*);

  // table copy
  logic [15:0] timeout_s;
  logic [3:0]  retry_max;
  logic        c_valid[NCACHE];
  logic [31:0] c_ip[NCACHE];
  logic [47:0] c_mac[NCACHE];
  logic [15:0] c_age[NCACHE];
  logic        p_valid[NPEND];
  logic [31:0] p_ip[NPEND];
  logic [3:0]  p_tries[NPEND];

  arp_result_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  bit no_gaps = 0;
  logic [31:0] ip_pool[8];

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic void push_result(logic [2:0] k, logic [31:0] ip, logic [47:0] mac,
                                      logic h, logic a, logic l);
    arp_result_t r;
    r.kind = k; r.ip = ip; r.mac = mac; r.hit = h; r.acc = a; r.last = l;
    pending_results.push_back(r);
  endfunction

  function automatic void predict_arp(logic [1:0] mode, logic [31:0] ip, logic [47:0] mac);
    logic found, flag;
    logic [47:0] m;
    found = 0; flag = 0; m = '0;
    case (mode)
      MODE_LOOKUP: begin
        for (int i = 0; i < NCACHE; i++)
          if (c_valid[i] && c_ip[i] == ip) begin
            found = 1; m = c_mac[i];
          end
        push_result(KIND_LOOKUP, ip, m, found, 0, 1);
      end
      MODE_INSERT: begin
        for (int i = 0; i < NPEND; i++)
          if (p_valid[i] && p_ip[i] == ip) begin
            p_valid[i] = 0; found = 1; break;
          end
        for (int i = 0; i < NCACHE; i++)
          if (!c_valid[i]) begin
            c_valid[i] = 1; c_ip[i] = ip; c_mac[i] = mac; c_age[i] = 0; flag = 1; break;
          end
        push_result(KIND_INSERT, ip, '0, found, flag, 1);
      end
      MODE_QUEUE: begin
        for (int i = 0; i < NPEND; i++)
          if (p_valid[i] && p_ip[i] == ip) begin
            found = 1; break;
          end
        if (!found)
          for (int i = 0; i < NPEND; i++)
            if (!p_valid[i]) begin
              p_valid[i] = 1; p_ip[i] = ip; p_tries[i] = 0; flag = 1; break;
            end
        push_result(KIND_QUEUE, ip, '0, found, flag, 1);
      end
      default: begin
        for (int i = 0; i < NCACHE; i++)
          if (c_valid[i]) begin
            if (c_age[i] != 16'hFFFF) c_age[i] = c_age[i] + 1;
            if (c_age[i] > timeout_s) c_valid[i] = 0;
          end
        for (int i = 0; i < NPEND; i++)
          if (p_valid[i]) begin
            if (p_tries[i] >= retry_max) begin
              push_result(KIND_GIVEUP, p_ip[i], '0, 0, 0, 0);
              p_valid[i] = 0;
            end else begin
              push_result(KIND_SEND, p_ip[i], '0, 0, 0, 0);
              p_tries[i] = p_tries[i] + 1;
            end
          end
        push_result(KIND_DONE, '0, '0, 0, 0, 1);
      end
    endcase
  endfunction

  always @(posedge clk_i) begin
    arp_result_t e;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result kind %0d ip %h", kind_o, result_ip_o);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (kind_o !== e.kind) begin
          $error("kind: expected %0d, got %0d", e.kind, kind_o); errors++;
        end
        if (result_ip_o !== e.ip) begin
          $error("result_ip: expected %h, got %h", e.ip, result_ip_o); errors++;
        end
        if (result_mac_o !== e.mac) begin
          $error("result_mac: expected %h, got %h", e.mac, result_mac_o); errors++;
        end
        if (hit_o !== e.hit) begin
          $error("hit: expected %b, got %b", e.hit, hit_o); errors++;
        end
        if (accepted_o !== e.acc) begin
          $error("accepted: expected %b, got %b", e.acc, accepted_o); errors++;
        end
        if (last_o !== e.last) begin
          $error("last: expected %b, got %b", e.last, last_o); errors++;
        end
      end
    end
  end

  task automatic send_item(logic [1:0] mode, logic [31:0] ip, logic [47:0] mac);
    int gap;
    if (!no_gaps) begin
      gap = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(10, 60);
      repeat (gap) @(negedge clk_i);
    end
    start = 1; mode_i = mode; ip_addr_i = ip; mac_addr_i = mac;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    predict_arp(mode, ip, mac);
    @(negedge clk_i);
    start = 0;
  endtask

  task automatic drain;
    while (pending_results.size() != 0 || busy) @(posedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [15:0] data);
    drain();
    cfg_we_i = 1; cfg_idx_i = idx; cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 0;
    if (idx == IDX_TIMEOUT) timeout_s = data;
    else if (idx == IDX_RETRY) retry_max = data[3:0];
  endtask

  function automatic logic [47:0] rand_mac();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[47:0];
  endfunction

  task automatic test_basic;
    send_item(MODE_LOOKUP, 32'h0, 48'h0);
    send_item(MODE_INSERT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_item(MODE_LOOKUP, 32'hFFFF_FFFF, 48'h0);
    send_item(MODE_INSERT, 32'h0, 48'h0);
    send_item(MODE_INSERT, 32'h0, 48'h1234_5678_9ABC);
    send_item(MODE_LOOKUP, 32'h0, 48'hFFFF_FFFF_FFFF);
    send_item(MODE_QUEUE, 32'hC0A8_0001, 48'h0);
    send_item(MODE_QUEUE, 32'hC0A8_0001, 48'h0);
    send_item(MODE_TICK, 32'h0, 48'h0);
    send_item(MODE_INSERT, 32'hC0A8_0001, rand_mac());
    send_item(MODE_TICK, 32'h0, 48'h0);
  endtask

  task automatic test_retry;
    write_cfg(IDX_RETRY, 16'd0);
    send_item(MODE_QUEUE, 32'h0A00_0001, 48'h0);
    send_item(MODE_TICK, 32'h0, 48'h0);
    write_cfg(IDX_RETRY, 16'hFFF2);
    write_cfg(IDX_SPARE, 16'h0003);
    send_item(MODE_QUEUE, 32'h0A00_0002, 48'h0);
    repeat (4) send_item(MODE_TICK, 32'h0, 48'h0);
  endtask

  task automatic test_pending_full;
    write_cfg(IDX_RETRY, 16'd15);
    for (int i = 0; i < NPEND + 1; i++) send_item(MODE_QUEUE, 32'h0B00_0000 + i, 48'h0);
    send_item(MODE_TICK, 32'h0, 48'h0);
  endtask

  task automatic test_cache_full;
    no_gaps = 1;
    write_cfg(IDX_TIMEOUT, 16'hFFFF);
    for (int i = 0; i < NCACHE + 1; i++) send_item(MODE_INSERT, 32'h0C00_0000 + i, rand_mac());
    send_item(MODE_LOOKUP, 32'h0C00_0000 + NCACHE - 1, 48'h0);
    send_item(MODE_TICK, 32'h0, 48'h0);
    no_gaps = 0;
    write_cfg(IDX_TIMEOUT, 16'd0);
    send_item(MODE_TICK, 32'h0, 48'h0);
    send_item(MODE_LOOKUP, 32'h0C00_0000, 48'h0);
  endtask

  task automatic test_random;
    logic [1:0] mode;
    logic [31:0] ip;
    int r;
    write_cfg(IDX_TIMEOUT, 16'd6);
    write_cfg(IDX_RETRY, 16'd3);
    foreach (ip_pool[i]) ip_pool[i] = $urandom;
    for (int n = 0; n < 24; n++) begin
      if (n == 8) write_cfg(IDX_RETRY, 16'd1);
      if (n == 16) begin
        write_cfg(IDX_TIMEOUT, 16'd2);
        write_cfg(IDX_RETRY, 16'd6);
      end
      no_gaps = (n >= 10 && n < 14);
      if (n == 20) drain();
      r = $urandom_range(0, 9);
      mode = (r < 3) ? MODE_LOOKUP : (r < 6) ? MODE_INSERT : (r < 8) ? MODE_QUEUE : MODE_TICK;
      ip = ($urandom_range(0, 4) == 0) ? $urandom : ip_pool[$urandom_range(0, 7)];
      send_item(mode, ip, rand_mac());
    end
  endtask

  initial begin
    rst_ni = 0; start = 0; mode_i = '0; ip_addr_i = '0; mac_addr_i = '0;
    cfg_we_i = 0; cfg_idx_i = '0; cfg_data_i = '0;
    timeout_s = 16'd15; retry_max = 4'd5;
    for (int i = 0; i < NCACHE; i++) begin
      c_valid[i] = 0; c_ip[i] = '0; c_mac[i] = '0; c_age[i] = '0;
    end
    for (int i = 0; i < NPEND; i++) begin
      p_valid[i] = 0; p_ip[i] = '0; p_tries[i] = '0;
    end
    repeat (12) @(negedge clk_i);
    rst_ni = 1;
    repeat (2) @(negedge clk_i);
    test_basic();
    test_retry();
    test_pending_full();
    test_cache_full();
    test_random();
    drain();
    repeat (200) @(posedge clk_i);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule

FILE: filelist.f
rtl/arpc_pkg.sv
rtl/arpc_ctrl.sv
rtl/arpc_datapath.sv
rtl/arp_cache_with_request_retry_unit.sv
sim/tb_top.sv
